>>> rtl/fbhtc_pkg.sv
// Package for the frame builder: job descriptor, step codes and defaults.
// Used by every module of the frame builder; depends on nothing.
`default_nettype none
package fbhtc_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] HEAD_RESET = 8'h7a;
  localparam logic [7:0] TAIL_RESET = 8'h7b;

  // Input action codes
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_PAYLOAD = 1'b1;

  // Configuration register indexes
  localparam logic REG_HEAD = 1'b0;
  localparam logic REG_TAIL = 1'b1;

  // Output steps of one job; a payload job starts at STEP_MID
  localparam logic [2:0] STEP_HEAD = 3'd0;
  localparam logic [2:0] STEP_CMD  = 3'd1;
  localparam logic [2:0] STEP_MID  = 3'd2;
  localparam logic [2:0] STEP_SUM  = 3'd3;
  localparam logic [2:0] STEP_TAIL = 3'd4;

  typedef struct packed {
    logic       start;   // emit head and command before the middle byte
    logic [7:0] cmd;
    logic [7:0] mid;     // length for a start, data byte for a payload
    logic       fin;     // close the frame: checksum high byte and tail
    logic [7:0] sum_hi;
  } fbhtc_job_t;

  typedef struct packed {
    logic       valid;
    fbhtc_job_t job;
  } fbhtc_slot_t;

endpackage
`default_nettype wire

>>> rtl/frame_builder_head_tail_checksum.sv
// Top level of the byte frame builder: configuration registers, front end,
// job queue and byte sequencer. Depends on fbhtc_pkg and the fbhtc_* modules.
//
// Usage:
//  - Input channel (in_*): action 0 opens a frame with a command byte and a
//    payload length, action 1 carries one payload byte. Payload with no
//    frame open is dropped; a start abandons any open frame.
//  - Output channel (out_*): one frame byte per transfer: head, command,
//    length, payload bytes, checksum high byte, tail (end_of_frame set).
//  - Config port (cfg_*): index 0 writes the head byte, index 1 the tail
//    byte. Write only while no frame bytes are pending.
//  - Path: each item's job is queued, then loaded into the output register.
//  - Throughput: the sequencer produces one output byte per cycle while the
//    receiver is ready. A payload item yields its data byte, the last
//    payload also the checksum high byte and tail, a start the head,
//    command and length bytes (and the closing bytes with zero length).
//    Input items are taken every cycle while the 4-entry job queue has
//    room, so long start or closing items are absorbed by the queue.
//  - Reset: clears frame state, queue and output valid; head and tail
//    registers return to 0x7a and 0x7b.
//  - Stall: a stalled receiver holds the output register; the queue fills
//    and then in_ready drops until transfers resume.
`default_nettype none
module frame_builder_head_tail_checksum
  import fbhtc_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_action,
  input  wire logic [7:0] in_command_byte,
  input  wire logic [7:0] in_payload_length,
  input  wire logic [7:0] in_payload_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_frame_byte,
  output logic            out_end_of_frame,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  logic [7:0]  head_byte_r;
  logic [7:0]  tail_byte_r;
  fbhtc_slot_t push;
  fbhtc_slot_t head;
  logic        q_full;
  logic        pop;

  // Config registers: hold until written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_byte_r <= HEAD_RESET;
      tail_byte_r <= TAIL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEAD: head_byte_r <= cfg_wdata;
        REG_TAIL: tail_byte_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // Classify items and track the open frame and its sum
  fbhtc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_command_byte   (in_command_byte),
    .in_payload_length (in_payload_length),
    .in_payload_byte   (in_payload_byte),
    .q_full            (q_full),
    .push              (push)
  );

  // Decouple the input rate from the output byte rate
  fbhtc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  // Expand jobs into frame bytes
  fbhtc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .head_byte        (head_byte_r),
    .tail_byte        (tail_byte_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_byte   (out_frame_byte),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule
`default_nettype wire

>>> rtl/fbhtc_front.sv
// Front end: accepts input items, tracks the open frame and its running sum,
// and turns each item into a job for the queue. Depends on fbhtc_pkg.
`default_nettype none
module fbhtc_front
  import fbhtc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_command_byte,
  input  wire logic [7:0]  in_payload_length,
  input  wire logic [7:0]  in_payload_byte,
  input  wire logic        q_full,
  output fbhtc_slot_t      push
);

  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  remaining_r, remaining_nxt;
  logic        open_r, open_nxt;
  logic        take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    sum_nxt       = sum_r;
    remaining_nxt = remaining_r;
    open_nxt      = open_r;
    push          = '0;
    if (take) begin
      if (in_action == ACT_START) begin
        sum_nxt       = {8'd0, in_command_byte} + {8'd0, in_payload_length};
        remaining_nxt = in_payload_length;
        open_nxt      = (in_payload_length != 8'd0);
        push.valid    = 1'b1;
        push.job.start  = 1'b1;
        push.job.cmd    = in_command_byte;
        push.job.mid    = in_payload_length;
        push.job.fin    = (in_payload_length == 8'd0);
        push.job.sum_hi = sum_nxt[15:8];
      end else if (open_r) begin
        sum_nxt       = sum_r + {8'd0, in_payload_byte};
        remaining_nxt = remaining_r - 8'd1;
        open_nxt      = (remaining_nxt != 8'd0);
        push.valid    = 1'b1;
        push.job.start  = 1'b0;
        push.job.cmd    = 8'd0;
        push.job.mid    = in_payload_byte;
        push.job.fin    = (remaining_nxt == 8'd0);
        push.job.sum_hi = sum_nxt[15:8];
      end
      // payload with no frame open: drop
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      remaining_r <= '0;
      open_r      <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      remaining_r <= remaining_nxt;
      open_r      <= open_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/fbhtc_queue.sv
// Short job queue between the front end and the byte sequencer.
// Depends on fbhtc_pkg.
`default_nettype none
module fbhtc_queue
  import fbhtc_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  fbhtc_slot_t push,
  output logic        full,
  output fbhtc_slot_t head,
  input  wire logic   pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  fbhtc_job_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign do_push    = push.valid && !full;
  assign head.valid = (count_r != '0);
  assign head.job   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/fbhtc_back.sv
// Back end: walks the job at the queue head into the output register, one
// byte per cycle while that register is free or taken. Depends on fbhtc_pkg.
`default_nettype none
module fbhtc_back
  import fbhtc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  fbhtc_slot_t     head,
  output logic            pop,
  input  wire logic [7:0] head_byte,
  input  wire logic [7:0] tail_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_frame_byte,
  output logic            out_end_of_frame
);

  logic [2:0] step_r, step_nxt;
  logic [2:0] cur_step, last_step;
  logic [7:0] byte_sel;
  logic       load;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       eof_r;

  assign cur_step  = head.job.start ? step_r : step_r + STEP_MID;
  assign last_step = head.job.fin ? STEP_TAIL : STEP_MID;
  assign load      = head.valid && (!valid_r || out_ready);
  assign pop       = load && (cur_step == last_step);

  always_comb begin
    unique case (cur_step)
      STEP_HEAD: byte_sel = head_byte;
      STEP_CMD:  byte_sel = head.job.cmd;
      STEP_MID:  byte_sel = head.job.mid;
      STEP_SUM:  byte_sel = head.job.sum_hi;
      STEP_TAIL: byte_sel = tail_byte;
      default:   byte_sel = 8'd0;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (pop) begin
      step_nxt = '0;
    end else if (load) begin
      step_nxt = step_r + 3'd1;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_sel;
      eof_r  <= (cur_step == STEP_TAIL);
    end
  end

  assign out_valid        = valid_r;
  assign out_frame_byte   = byte_r;
  assign out_end_of_frame = eof_r;

endmodule
`default_nettype wire

>>> rtl/fbhtc_checker.sv
// Port-level checks for the frame builder, bound to the top level.
// Depends on fbhtc_pkg and frame_builder_head_tail_checksum.
`default_nettype none
module fbhtc_checker
  import fbhtc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_frame_byte,
  input wire logic       out_end_of_frame,
  input wire logic       cfg_we,
  input wire logic       cfg_index,
  input wire logic [7:0] cfg_wdata
);

  logic [7:0] tail_shadow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_shadow_r <= TAIL_RESET;
    end else if (cfg_we && cfg_index == REG_TAIL) begin
      tail_shadow_r <= cfg_wdata;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_frame_byte) && $stable(out_end_of_frame))
    else $error("stalled output changed");

  a_tail_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_frame |-> out_frame_byte == tail_shadow_r)
    else $error("end of frame byte is not the tail byte");

  a_backpressure_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no output pending");

endmodule

bind frame_builder_head_tail_checksum fbhtc_checker u_fbhtc_checker (.*);
`default_nettype wire

>>> dv/tb_frame_builder_head_tail_checksum.sv
// Testbench for frame_builder_head_tail_checksum: directed and random frames
// checked against a cycle-free model of the byte stream. Depends on fbhtc_pkg
// and the frame builder RTL.
`default_nettype none
module tb_frame_builder_head_tail_checksum;
  import fbhtc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 2000; // cycles with no transfer at all
  localparam int unsigned SETTLE_CYCLES  = 8;    // drain a dropped payload before cfg
  localparam int unsigned DRAIN_CYCLES   = 16;   // catch stray bytes at the end

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } frame_out_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_action = ACT_START;
  logic [7:0] in_command_byte = 8'h00;
  logic [7:0] in_payload_length = 8'h00;
  logic [7:0] in_payload_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_frame_byte;
  logic       out_end_of_frame;
  logic       cfg_we = 1'b0;
  logic       cfg_index = REG_HEAD;
  logic [7:0] cfg_wdata = 8'h00;

  frame_builder_head_tail_checksum dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_command_byte  (in_command_byte),
    .in_payload_length(in_payload_length),
    .in_payload_byte  (in_payload_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_byte   (out_frame_byte),
    .out_end_of_frame (out_end_of_frame),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Shadow copy of the block state: delimiter registers and the open frame.
  logic [7:0]  head_shadow = HEAD_RESET;
  logic [7:0]  tail_shadow = TAIL_RESET;
  logic [15:0] checksum_acc = 16'h0000;
  logic [7:0]  bytes_left = 8'h00;
  logic        frame_is_open = 1'b0;

  frame_out_t  expected_frame_bytes[$];
  int unsigned error_count = 0;
  int unsigned burst_left = 0;

  // ---------------------------------------------------------------------------
  // Byte stream prediction
  // ---------------------------------------------------------------------------
  task automatic expect_byte(input logic [7:0] value, input logic last);
    expected_frame_bytes.push_back('{frame_byte: value, end_of_frame: last});
  endtask

  // Checksum high byte then the tail, which carries end_of_frame.
  task automatic close_frame();
    expect_byte(checksum_acc[15:8], 1'b0);
    expect_byte(tail_shadow, 1'b1);
    frame_is_open = 1'b0;
    bytes_left    = 8'h00;
  endtask

  task automatic predict_frame_bytes(input logic act, input logic [7:0] cmd,
                                     input logic [7:0] len, input logic [7:0] data);
    if (act == ACT_START) begin
      // A start always opens a fresh frame, abandoning whatever was open.
      expect_byte(head_shadow, 1'b0);
      expect_byte(cmd, 1'b0);
      expect_byte(len, 1'b0);
      checksum_acc  = {8'h00, cmd} + {8'h00, len};
      bytes_left    = len;
      frame_is_open = 1'b1;
      if (len == 8'h00) close_frame();
    end else if (frame_is_open) begin
      expect_byte(data, 1'b0);
      checksum_acc = checksum_acc + {8'h00, data};
      bytes_left   = bytes_left - 8'h01;
      if (bytes_left == 8'h00) close_frame();
    end
    // Payload with no frame open is dropped: nothing to expect.
  endtask

  // ---------------------------------------------------------------------------
  // Input side: one transfer per call, bursts separated by random gaps.
  // Valid stays high after the transfer so back-to-back items need no toggle.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic act, input logic [7:0] cmd,
                           input logic [7:0] len, input logic [7:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // Mostly short bursts, now and then a long stretch at full rate.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
    end
    predict_frame_bytes(act, cmd, len, data);
    in_valid          <= 1'b1;
    in_action         <= act;
    in_command_byte   <= cmd;
    in_payload_length <= len;
    in_payload_byte   <= data;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // Unused fields of each action get random values so they are exercised too.
  task automatic send_start(input logic [7:0] cmd, input logic [7:0] len);
    send_item(ACT_START, cmd, len, 8'($urandom));
  endtask

  task automatic send_payload(input logic [7:0] data);
    send_item(ACT_PAYLOAD, 8'($urandom), 8'($urandom), data);
  endtask

  // Drop valid, let every expected byte arrive, then drain the pipeline.
  task automatic wait_idle();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (expected_frame_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both delimiter registers on consecutive edges; call only when idle.
  task automatic set_delimiters(input logic [7:0] head, input logic [7:0] tail);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HEAD;
    cfg_wdata <= head;
    @(posedge clk);
    head_shadow = head;
    cfg_index <= REG_TAIL;
    cfg_wdata <= tail;
    @(posedge clk);
    tail_shadow = tail;
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: receiver stalls follow a pattern picked at random for each
  // stretch of the run (always ready, random, periodic stall bursts).
  // ---------------------------------------------------------------------------
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;

  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(20, 80);
    end
    rx_mode_left--;
    case (rx_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 9) < 7);
      end
      default: begin
        out_ready <= ((rx_mode_left % 16) >= 10) ? 1'b0 : 1'b1;
      end
    endcase
  end

  // Compare every accepted byte with the oldest expectation.
  always @(posedge clk) begin
    frame_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_frame_bytes.size() == 0) begin
        $error("unexpected frame byte %02h (end_of_frame %0b)",
               out_frame_byte, out_end_of_frame);
        error_count++;
      end else begin
        want = expected_frame_bytes.pop_front();
        if (out_frame_byte !== want.frame_byte) begin
          $error("frame_byte: expected %02h, actual %02h", want.frame_byte, out_frame_byte);
          error_count++;
        end
        if (out_end_of_frame !== want.end_of_frame) begin
          $error("end_of_frame: expected %0b, actual %0b",
                 want.end_of_frame, out_end_of_frame);
          error_count++;
        end
      end
    end
  end

  // Watchdog: abort when no transfer happens on any port for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL frame_builder_head_tail_checksum");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset delimiters, stray payload, zero-length frames and field extremes.
  task automatic test_reset_delimiters_and_extremes();
    send_payload(8'hFF);          // no frame open yet: dropped
    send_start(8'h00, 8'h00);     // five bytes, all-zero checksum
    send_start(8'hFF, 8'h00);
    send_start(8'hA5, 8'h03);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'h5A);          // closes the frame
    send_payload(8'h3C);          // after the tail: dropped
    send_start(8'h01, 8'h01);
    send_payload(8'h80);
  endtask

  // A new start in the middle of a frame abandons it without checksum or tail.
  task automatic test_abandoned_frames();
    send_start(8'h42, 8'h03);
    send_payload(8'h11);
    send_start(8'h43, 8'h01);     // abandon after one payload byte
    send_payload(8'h22);
    send_start(8'h44, 8'h02);
    send_start(8'h45, 8'h00);     // abandon with no payload sent
    send_start(8'h46, 8'h02);
    send_payload(8'hFE);
    send_payload(8'h01);
    send_payload(8'h99);          // closed again: dropped
  endtask

  // Longest frame with command, length and every payload byte at 0xFF: checksum reaches 0xFFFF exactly.
  task automatic test_max_checksum_frame();
    wait_idle();
    set_delimiters(8'h00, 8'hFF);
    send_start(8'hFF, 8'hFF);
    repeat (255) send_payload(8'hFF);
  endtask

  // Random frames, mostly well formed, with abandoned frames and stray bytes
  // mixed in. Delimiters change between phases, extremes first.
  task automatic test_random_frames(input int unsigned total_items);
    int unsigned phase_items;
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0: set_delimiters(8'hFF, 8'h00);
        1: set_delimiters(HEAD_RESET, TAIL_RESET);
        default: set_delimiters(8'($urandom), 8'($urandom));
      endcase
      phase_items = total_items / 4;
      sent = 0;
      while (sent < phase_items) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) len = 0;
        else if (pick < 90) len = $urandom_range(1, 8);
        else len = $urandom_range(9, 40);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // Stray payload byte: dropped unless a cut-short frame is still open.
          send_payload(8'($urandom));
        end else begin
          // Cut some frames short so the next start abandons them.
          cut = (pick < 18 && len > 1) ? $urandom_range(0, len - 1) : len;
          send_start(8'($urandom), 8'(len));
          sent++;
          repeat (cut) begin
            send_payload(8'($urandom));
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_delimiters_and_extremes();
    test_abandoned_frames();
    test_max_checksum_frame();
    test_random_frames(180);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS frame_builder_head_tail_checksum");
    end else begin
      $display("FAIL frame_builder_head_tail_checksum");
    end
    $finish;
  end

endmodule
`default_nettype wire
